// ----- sv/xbd_pkg.sv -----
package xbd_pkg;

  localparam logic [63:0] SEED_WORD_B = 64'h82A2_B175_229D_6A5B;

  // Rejection draw step limit and its counter width.
  localparam int unsigned MAX_TRIES = 64;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STEPS_W   = 7;
  localparam int unsigned STEPS_SAT = 127;

  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_A = 16;
  localparam int unsigned ROT_B   = 37;

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_MASKED = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

endpackage

// ----- sv/xbd_gen.sv -----
module xbd_gen import xbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gen_ctrl_t   ctrl_i,
  input  logic [63:0] seed_i,
  output logic [63:0] sum_o
);

  logic [63:0] word_a_q, word_a_d;
  logic [63:0] word_b_q, word_b_d;
  logic [63:0] mix;

  assign sum_o = word_a_q + word_b_q;
  assign mix   = word_a_q ^ word_b_q;

  always_comb begin
    word_a_d = word_a_q;
    word_b_d = word_b_q;
    if (ctrl_i.load) begin
      word_a_d = seed_i;
      word_b_d = SEED_WORD_B;
    end else if (ctrl_i.step) begin
      word_a_d = {word_a_q[63-ROT_A:0], word_a_q[63:64-ROT_A]} ^ mix ^ (mix << SHIFT_A);
      word_b_d = {mix[63-ROT_B:0], mix[63:64-ROT_B]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= '0;
      word_b_q <= SEED_WORD_B;
    end else begin
      word_a_q <= word_a_d;
      word_b_q <= word_b_d;
    end
  end

endmodule

// ----- sv/xoroshiro_bounded_draw_top.sv -----
// Bounded draw unit built around a xoroshiro128+ generator.
//
// Input channel (in_valid_i / in_ready_o) carries one command beat: kind_i
// selects reseed, raw 64-bit draw, masked draw or rejection draw below
// upper_bound_i. Output channel (out_valid_o / out_ready_i) returns exactly
// one result beat per command: value_o, steps_used_o and gave_up_o.
//
// Timing: a command is taken only while the sequencer is idle. A reseed loads
// the generator once the output register is free and then returns its beat. A
// draw runs one generator step per cycle on the shared step unit, bar a final
// step held while the output register is occupied: 1 step for raw and masked
// draws, 1..MAX_TRIES for a rejection draw. A new command is taken only once
// the last one has finished its steps and the sequencer is back in idle.
//
// Reset puts the generator at word_a = 0, word_b = the seed constant, clears
// the sequencer and drops out_valid_o. The result sits in an output register,
// so the next command is taken while it waits; if the receiver stalls, the
// sequencer holds the final step, or a reseed's load, until the output register frees up.
module xoroshiro_bounded_draw_top import xbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] seed_value_i,
  input  logic [31:0] upper_bound_i,
  input  logic [31:0] draw_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [6:0]  steps_used_o,
  output logic        gave_up_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [63:0]         seed_q, seed_d;
  logic [31:0]         bound_q, bound_d;
  logic [31:0]         mask_q, mask_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         value_q, value_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic                gave_up_q, gave_up_d;

  gen_ctrl_t           gen_ctrl;
  logic [63:0]         sum;
  logic [31:0]         masked;
  logic                hit;
  logic                last_try;
  logic                done;
  logic                slot_free;
  logic [CNT_W:0]      steps_now;
  logic [STEPS_W-1:0]  steps_sat;

  xbd_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (seed_q),
    .sum_o  (sum)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign steps_used_o = steps_q;
  assign gave_up_o    = gave_up_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign masked    = sum[31:0] & mask_q;
  assign hit       = masked < bound_q;
  assign last_try  = cnt_q == CNT_W'(MAX_TRIES - 1);
  // A draw finishes on this step unless a rejection draw misses with tries left.
  assign done      = (kind_q != KIND_REJECT) || hit || last_try;

  assign steps_now = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign steps_sat = (steps_now > (CNT_W+1)'(STEPS_SAT)) ? STEPS_W'(STEPS_SAT)
                                                         : steps_now[STEPS_W-1:0];

  always_comb begin
    gen_ctrl.load = 1'b0;
    gen_ctrl.step = 1'b0;
    if (state_q == ST_RUN) begin
      if (kind_q == KIND_RESEED) begin
        gen_ctrl.load = slot_free;
      end else begin
        // Hold the final step while the output register is still occupied.
        gen_ctrl.step = !done || slot_free;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    seed_d      = seed_q;
    bound_d     = bound_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    steps_d     = steps_q;
    gave_up_d   = gave_up_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_e'(kind_i);
          seed_d  = seed_value_i;
          bound_d = upper_bound_i;
          mask_d  = draw_mask_i;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (gen_ctrl.load) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          steps_d     = '0;
          gave_up_d   = 1'b0;
          state_d     = ST_IDLE;
        end else if (gen_ctrl.step) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (done) begin
            out_valid_d = 1'b1;
            steps_d     = steps_sat;
            gave_up_d   = 1'b0;
            state_d     = ST_IDLE;
            case (kind_q)
              KIND_RAW:    value_d = sum;
              KIND_MASKED: value_d = {32'd0, masked};
              default: begin
                if (hit) begin
                  value_d = {32'd0, masked};
                end else begin
                  value_d   = '0;
                  gave_up_d = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_RESEED;
      seed_q      <= '0;
      bound_q     <= '0;
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      steps_q     <= '0;
      gave_up_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      seed_q      <= seed_d;
      bound_q     <= bound_d;
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      value_q     <= value_d;
      steps_q     <= steps_d;
      gave_up_q   <= gave_up_d;
    end
  end

endmodule

// ----- bench/xbd_draw_checker.sv -----
`timescale 1ns / 1ps

module xbd_draw_checker import xbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [63:0] seed_value_i,
  input  logic [31:0] upper_bound_i,
  input  logic [31:0] draw_mask_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] value_i,
  input  logic [6:0]  steps_used_i,
  input  logic        gave_up_i,
  output int unsigned mismatch_count_o,
  output int unsigned draws_pending_o
);

  typedef struct packed {
    logic [63:0]        value;
    logic [STEPS_W-1:0] steps;
    logic               gave_up;
  } draw_result_t;

  draw_result_t pending_draws[$];

  // Shadow copy of the generator state.
  logic [63:0] gen_a = '0;
  logic [63:0] gen_b = SEED_WORD_B;

  initial begin
    mismatch_count_o = 0;
    draws_pending_o  = 0;
  end

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // One generator step: return the sum and advance the shadow state.
  function logic [63:0] advance_gen();
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] sum;
    s0 = gen_a;
    s1 = gen_b;
    sum = s0 + s1;
    s1 = s1 ^ s0;
    gen_a = ((s0 << ROT_A) | (s0 >> (64 - ROT_A))) ^ s1 ^ (s1 << SHIFT_A);
    gen_b = (s1 << ROT_B) | (s1 >> (64 - ROT_B));
    return sum;
  endfunction

  function draw_result_t predict_draw(input kind_e kind, input logic [63:0] seed,
                                      input logic [31:0] bound, input logic [31:0] mask);
    draw_result_t res;
    int unsigned  tries;
    logic [63:0]  raw;
    logic [31:0]  masked;
    logic         hit;
    res = '0;
    tries = 0;
    hit = 1'b0;
    masked = '0;
    case (kind)
      KIND_RESEED: begin
        gen_a = seed;
        gen_b = SEED_WORD_B;
      end
      KIND_RAW: begin
        res.value = advance_gen();
        tries = 1;
      end
      KIND_MASKED: begin
        raw = advance_gen();
        res.value = {32'b0, raw[31:0] & mask};
        tries = 1;
      end
      default: begin
        // Retry until below the bound; give up after the step limit.
        while (tries < MAX_TRIES && !hit) begin
          raw = advance_gen();
          masked = raw[31:0] & mask;
          tries++;
          hit = (masked < bound);
        end
        if (hit) res.value = {32'b0, masked};
        else res.gave_up = 1'b1;
      end
    endcase
    res.steps = (tries > STEPS_SAT) ? STEPS_W'(STEPS_SAT) : STEPS_W'(tries);
    return res;
  endfunction

  always @(posedge clk_i) begin
    draw_result_t want;
    if (!rst_ni) begin
      gen_a = '0;
      gen_b = SEED_WORD_B;
      pending_draws.delete();
    end else begin
      // Retire the result beat first: it can never belong to this edge's command.
      if (out_valid_i && out_ready_i) begin
        if (pending_draws.size() == 0) begin
          report_mismatch("result beat with nothing pending", value_i, '0);
        end else begin
          want = pending_draws.pop_front();
          if (value_i !== want.value)
            report_mismatch("value", value_i, want.value);
          if (steps_used_i !== want.steps)
            report_mismatch("steps_used", 64'(steps_used_i), 64'(want.steps));
          if (gave_up_i !== want.gave_up)
            report_mismatch("gave_up", 64'(gave_up_i), 64'(want.gave_up));
        end
      end
      if (in_valid_i && in_ready_i)
        pending_draws.push_back(predict_draw(kind_e'(kind_i), seed_value_i,
                                             upper_bound_i, draw_mask_i));
    end
    draws_pending_o = pending_draws.size();
  end

endmodule

// ----- bench/xoroshiro_bounded_draw_top_tb.sv -----
`timescale 1ns / 1ps

module xoroshiro_bounded_draw_top_tb;
  import xbd_pkg::*;

  localparam int RANDOM_ITEMS = 830;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kind_e       kind = KIND_RESEED;
  logic [63:0] seed_value = '0;
  logic [31:0] upper_bound = '0;
  logic [31:0] draw_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic [6:0]  steps_used;
  logic        gave_up;

  int unsigned mismatches;
  int unsigned draws_pending;

  // Sender burst bookkeeping: beats left in this burst, idle cycles before the next.
  int burst_left = 12;
  int gap_left = 0;

  always #6 clk = ~clk;

  xoroshiro_bounded_draw_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .seed_value_i (seed_value),
    .upper_bound_i(upper_bound),
    .draw_mask_i  (draw_mask),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_o      (value),
    .steps_used_o (steps_used),
    .gave_up_o    (gave_up)
  );

  xbd_draw_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .kind_i          (kind),
    .seed_value_i    (seed_value),
    .upper_bound_i   (upper_bound),
    .draw_mask_i     (draw_mask),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .value_i         (value),
    .steps_used_i    (steps_used),
    .gave_up_i       (gave_up),
    .mismatch_count_o(mismatches),
    .draws_pending_o (draws_pending)
  );

  // Offer one command beat. Called at a falling edge; returns at the falling
  // edge after the beat is taken, with valid still high; any gap is idled at the next call.
  task automatic send_cmd(input kind_e k, input logic [63:0] seed,
                          input logic [31:0] bound, input logic [31:0] mask);
    if (gap_left > 0) begin
      in_valid = 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    in_valid    = 1'b1;
    kind        = k;
    seed_value  = seed;
    upper_bound = bound;
    draw_mask   = mask;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      // Mostly short bursts, now and then a long one with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap_left   = $urandom_range(1, 8);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random command: rejection draws get bound/mask pairs that land anywhere
  // from an immediate hit to a full give-up.
  task automatic send_random_cmd();
    int unsigned pick;
    int unsigned shape;
    logic [31:0] mask;
    logic [31:0] bound;
    kind_e       k;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    mask  = $urandom;
    bound = $urandom;
    if (pick < 10)      k = KIND_RESEED;
    else if (pick < 35) k = KIND_RAW;
    else if (pick < 60) k = KIND_MASKED;
    else                k = KIND_REJECT;
    if (k == KIND_REJECT) begin
      case (shape)
        0: bound = '0;
        1, 2, 3: begin
          mask  = 32'hFFFF_FFFF >> $urandom_range(0, 31);
          bound = $urandom_range(0, mask) + 1;
        end
        4, 5: mask = 32'hFFFF_FFFF;
        6: bound = $urandom_range(1, 64);
        default: ;
      endcase
    end else if (k == KIND_MASKED && shape < 2) begin
      mask = shape[0] ? 32'hFFFF_FFFF : '0;
    end
    send_cmd(k, rand64(), bound, mask);
  endtask

  // Receiver: segments of always-ready, coin-flip and sparse acceptance,
  // plus one long hold-off so the result register backs up into the input.
  initial begin
    int seg_len;
    int mode;
    int seg_no;
    seg_no = 0;
    @(posedge rst_n);
    forever begin
      if (seg_no == 12) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      seg_len = $urandom_range(1, 40);
      mode    = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      seg_no++;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Draws straight from the reset state, then edge masks.
    send_cmd(KIND_RAW,    rand64(), $urandom, $urandom);
    send_cmd(KIND_MASKED, rand64(), $urandom, 32'h0000_0000);
    send_cmd(KIND_MASKED, rand64(), $urandom, 32'hFFFF_FFFF);
    // Reseed at both seed extremes; unused fields carry all-ones or all-zeros.
    send_cmd(KIND_RESEED, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_RAW,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
    send_cmd(KIND_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
    send_cmd(KIND_RAW,    64'h0, $urandom, $urandom);
    // Zero bound always gives up, whatever the mask.
    send_cmd(KIND_REJECT, rand64(), 32'h0, 32'hFFFF_FFFF);
    send_cmd(KIND_REJECT, rand64(), 32'h0, 32'h0);
    // Widest bound with a full mask: hit on the first step almost surely.
    send_cmd(KIND_REJECT, rand64(), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero mask under a bound of one: value 0 at once.
    send_cmd(KIND_REJECT, rand64(), 32'h1, 32'h0);
    // One-bit mask: a handful of retries.
    send_cmd(KIND_REJECT, rand64(), 32'h1, 32'h1);
    send_cmd(KIND_REJECT, rand64(), 32'h1, 32'h1);
    // Tiny bound under a full mask: runs out the step limit.
    send_cmd(KIND_REJECT, rand64(), 32'h10, 32'hFFFF_FFFF);
    send_cmd(KIND_RESEED, rand64(), $urandom, $urandom);
    send_cmd(KIND_MASKED, rand64(), $urandom, 32'hAAAA_5555);
    send_cmd(KIND_REJECT, rand64(), 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(KIND_RAW,    rand64(), $urandom, $urandom);
    send_cmd(KIND_REJECT, rand64(), 32'h0000_0100, 32'h0000_01FF);

    repeat (RANDOM_ITEMS) send_random_cmd();
    in_valid = 1'b0;

    // Drain, then give a slow rejection draw time to show up uninvited.
    wait (draws_pending == 0);
    repeat (MAX_TRIES + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
